### design/mltok_pkg.sv
// Package holding the types and character constants shared by the metric line tokenizer.
package mltok_pkg;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;

    typedef enum logic [2:0] {
        PH_KEY         = 3'd0,
        PH_LABEL       = 3'd1,
        PH_AFTER_LABEL = 3'd2,
        PH_VALUE       = 3'd3,
        PH_BREAK       = 3'd4,
        PH_ERROR       = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CL_KEY    = 3'd0,
        CL_LNAME  = 3'd1,
        CL_LVALUE = 3'd2,
        CL_VALUE  = 3'd3,
        CL_DELIM  = 3'd4,
        CL_BREAK  = 3'd5,
        CL_DROP   = 3'd6
    } t_class;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_EQUAL_IN_KEY  = 3'd1,
        ERR_BAD_LABEL     = 3'd2,
        ERR_UNEXPECTED    = 3'd3,
        ERR_MISSING_VALUE = 3'd4
    } t_err;

    typedef struct packed {
        t_phase phase;
        logic   saw_equal;
        logic   label_value_seen;
        logic   value_seen;
    } t_state;

    localparam t_state STATE_RESET = '{phase: PH_KEY, saw_equal: 1'b0,
                                       label_value_seen: 1'b0, value_seen: 1'b0};

    typedef struct packed {
        logic [7:0] echo_byte;
        t_class     byte_class;
        logic       sample_done;
        t_err       error_code;
        logic       message_done;
    } t_result;

    function automatic logic is_break(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

### design/mltok_parse.sv
// Combinational tagger: classifies one byte and works out the next parser state.
module mltok_parse (
    input  mltok_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output mltok_pkg::t_state  o_state,
    output mltok_pkg::t_result o_result
);

    mltok_pkg::t_state n_st;
    mltok_pkg::t_class cls;
    mltok_pkg::t_err   err;
    logic              done;
    logic              key_path;
    logic              brk;

    always_comb begin
        n_st     = i_state;
        cls      = mltok_pkg::CL_DROP;
        err      = mltok_pkg::ERR_NONE;
        done     = 1'b0;
        key_path = 1'b0;
        brk      = mltok_pkg::is_break(i_byte);

        case (i_state.phase)
            mltok_pkg::PH_KEY: begin
                key_path = 1'b1;
            end
            mltok_pkg::PH_LABEL: begin
                if (i_byte == mltok_pkg::CH_RBRACKET || i_byte == mltok_pkg::CH_COLON) begin
                    if (!i_state.saw_equal || !i_state.label_value_seen) begin
                        err = mltok_pkg::ERR_BAD_LABEL;
                    end else begin
                        cls = mltok_pkg::CL_DELIM;
                        if (i_byte == mltok_pkg::CH_RBRACKET) begin
                            n_st.phase = mltok_pkg::PH_AFTER_LABEL;
                        end else begin
                            n_st.phase      = mltok_pkg::PH_VALUE;
                            n_st.value_seen = 1'b0;
                        end
                    end
                end else if (brk) begin
                    err = mltok_pkg::ERR_MISSING_VALUE;
                end else if (!i_state.saw_equal) begin
                    if (i_byte == mltok_pkg::CH_EQUAL) begin
                        cls            = mltok_pkg::CL_DELIM;
                        n_st.saw_equal = 1'b1;
                    end else begin
                        cls = mltok_pkg::CL_LNAME;
                    end
                end else begin
                    cls                   = mltok_pkg::CL_LVALUE;
                    n_st.label_value_seen = 1'b1;
                end
            end
            mltok_pkg::PH_AFTER_LABEL: begin
                if (i_byte == mltok_pkg::CH_LBRACKET) begin
                    cls                   = mltok_pkg::CL_DELIM;
                    n_st.phase            = mltok_pkg::PH_LABEL;
                    n_st.saw_equal        = 1'b0;
                    n_st.label_value_seen = 1'b0;
                end else if (i_byte == mltok_pkg::CH_COLON) begin
                    cls             = mltok_pkg::CL_DELIM;
                    n_st.phase      = mltok_pkg::PH_VALUE;
                    n_st.value_seen = 1'b0;
                end else begin
                    err = mltok_pkg::ERR_UNEXPECTED;
                end
            end
            mltok_pkg::PH_VALUE: begin
                if (brk) begin
                    if (i_state.value_seen) begin
                        cls        = mltok_pkg::CL_BREAK;
                        done       = 1'b1;
                        n_st.phase = mltok_pkg::PH_BREAK;
                    end else begin
                        err = mltok_pkg::ERR_MISSING_VALUE;
                    end
                end else begin
                    cls             = mltok_pkg::CL_VALUE;
                    n_st.value_seen = 1'b1;
                end
            end
            mltok_pkg::PH_BREAK: begin
                if (brk) begin
                    cls = mltok_pkg::CL_BREAK;
                end else begin
                    key_path = 1'b1;
                end
            end
            default: begin
                cls = mltok_pkg::CL_DROP;
            end
        endcase

        // A byte at the start of, or inside, a key.
        if (key_path) begin
            if (i_byte == mltok_pkg::CH_LBRACKET) begin
                cls                   = mltok_pkg::CL_DELIM;
                n_st.phase            = mltok_pkg::PH_LABEL;
                n_st.saw_equal        = 1'b0;
                n_st.label_value_seen = 1'b0;
            end else if (i_byte == mltok_pkg::CH_COLON) begin
                cls             = mltok_pkg::CL_DELIM;
                n_st.phase      = mltok_pkg::PH_VALUE;
                n_st.value_seen = 1'b0;
            end else if (i_byte == mltok_pkg::CH_EQUAL) begin
                err = mltok_pkg::ERR_EQUAL_IN_KEY;
            end else if (brk) begin
                err = mltok_pkg::ERR_MISSING_VALUE;
            end else begin
                cls        = mltok_pkg::CL_KEY;
                n_st.phase = mltok_pkg::PH_KEY;
            end
        end

        if (err != mltok_pkg::ERR_NONE) begin
            cls        = mltok_pkg::CL_DROP;
            n_st.phase = mltok_pkg::PH_ERROR;
        end

        // The end of the datagram closes any open sample and restarts the parser.
        if (i_last) begin
            if (n_st.phase != mltok_pkg::PH_ERROR && n_st.phase != mltok_pkg::PH_BREAK) begin
                if (n_st.phase == mltok_pkg::PH_VALUE && n_st.value_seen) begin
                    done = 1'b1;
                end else begin
                    err = mltok_pkg::ERR_MISSING_VALUE;
                    cls = mltok_pkg::CL_DROP;
                end
            end
            n_st = mltok_pkg::STATE_RESET;
        end
    end

    assign o_state               = n_st;
    assign o_result.echo_byte    = i_byte;
    assign o_result.byte_class   = cls;
    assign o_result.sample_done  = done;
    assign o_result.error_code   = err;
    assign o_result.message_done = i_last;

endmodule

### design/mltok_outreg.sv
// Result register with its valid flag, holding a transaction while the receiver stalls.
module mltok_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mltok_pkg::t_result i_result,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output mltok_pkg::t_result o_result
);

    logic               r_valid;
    logic               n_valid;
    mltok_pkg::t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### design/metric_line_tokenizer_top.sv
// Top level of the metric line tokenizer: input register, parser state and result register.
//
// Bytes of a metric datagram arrive on the input channel (i_in_valid, o_in_stall,
// i_data_byte, i_last_of_message), one transaction per byte. Each byte yields exactly
// one tagged result on the output channel (o_out_valid, i_out_stall and the result
// fields), in order.
// A byte is taken into the input register, tagged by the parser logic and written to
// the result register, which presents its result. The parser state updates in the
// same cycle as the tagging, so one byte per cycle is sustained with no bubbles while
// the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and the input
// register can still take one more byte; the input channel stalls only once both
// are full, and it is released in the cycle the receiver takes the held result.
// Synchronous active-low reset empties both registers and returns the parser to
// the key phase with all flags cleared. The last byte of a datagram also returns
// the parser to that state.
module metric_line_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_of_message,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_echo_byte,
    output logic [2:0] o_byte_class,
    output logic       o_sample_done,
    output logic [2:0] o_error_code,
    output logic       o_message_done
);

    logic               r_in_valid;
    logic               n_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    mltok_pkg::t_state  r_state;
    mltok_pkg::t_state  n_state;
    mltok_pkg::t_result parse_result;
    mltok_pkg::t_result out_result;
    logic               out_free;
    logic               advance;
    logic               accept;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= mltok_pkg::STATE_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_of_message;
        end
    end

    mltok_parse u_parse (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (parse_result)
    );

    mltok_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_in_valid),
        .i_result (parse_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_echo_byte    = out_result.echo_byte;
    assign o_byte_class   = out_result.byte_class;
    assign o_sample_done  = out_result.sample_done;
    assign o_error_code   = out_result.error_code;
    assign o_message_done = out_result.message_done;

endmodule
